/* rtl/core/inverse_histogram_weight_table_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the inverse histogram weight table
// Clocked, reset-qualified property checks used by the checker file.
// ---------------------------------------------------------------------------
`ifndef INVERSE_HISTOGRAM_WEIGHT_TABLE_MACROS_SVH
`define INVERSE_HISTOGRAM_WEIGHT_TABLE_MACROS_SVH

// Check an implication or sequence property on every rising edge out of reset
`define IHWT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ihwt property violated");

// Check that a condition never holds on a rising edge out of reset
`define IHWT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ihwt forbidden condition seen");

`endif

/* rtl/core/ihwt_pkg.sv */
// ---------------------------------------------------------------------------
// ihwt_pkg
// Sizes, command and status codes and shared types of the weight table.
// ---------------------------------------------------------------------------
package ihwt_pkg;

  // Table geometry and number formats
  localparam int MAX_BINS    = 1024;
  localparam int COUNT_BITS  = 24;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_BITS    = $clog2(MAX_BINS);
  localparam int FILL_BITS   = $clog2(MAX_BINS + 1);
  localparam int TOTAL_BITS  = COUNT_BITS + IDX_BITS;
  localparam int WEIGHT_BITS = FRAC_BITS + 1;
  localparam int STEP_BITS   = $clog2(WEIGHT_BITS + 1);

  // Fixed port field widths
  localparam int CMD_BITS       = 2;
  localparam int STATUS_BITS    = 2;
  localparam int IN_COUNT_BITS  = 24;
  localparam int IN_INDEX_BITS  = 10;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd2;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;

  // Weight of 1.0 in the output format
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << FRAC_BITS;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* rtl/core/ihwt_ram.sv */
// ---------------------------------------------------------------------------
// ihwt_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ihwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write beat, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/ihwt_div.sv */
// ---------------------------------------------------------------------------
// ihwt_div
// Restoring divider: (smallest << FRAC_BITS) / divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module ihwt_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ihwt_pkg::COUNT_BITS-1:0]     smallest,
  input  logic [ihwt_pkg::TOTAL_BITS-1:0]     divisor,
  output ihwt_pkg::div_status_t               status,
  output logic [ihwt_pkg::WEIGHT_BITS-1:0]    quotient
);

  logic [ihwt_pkg::TOTAL_BITS-1:0]  rem_r;
  logic [ihwt_pkg::TOTAL_BITS-1:0]  dvs_r;
  logic [ihwt_pkg::WEIGHT_BITS-1:0] quo_r;
  logic [ihwt_pkg::STEP_BITS-1:0]   step_r;
  logic                             shin_r;
  logic                             busy_r;
  logic                             done_r;

  logic [ihwt_pkg::TOTAL_BITS:0]    trial;
  logic [ihwt_pkg::TOTAL_BITS:0]    diff;
  logic                             fits;

  // Shift in the next numerator bit and trial-subtract the divisor
  always_comb begin
    trial = {rem_r, shin_r};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Control: start loads, then one step per cycle until the last quotient bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == ihwt_pkg::STEP_BITS'(ihwt_pkg::WEIGHT_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: high numerator bits seed the remainder, low bit and zeros follow
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= ihwt_pkg::TOTAL_BITS'({1'b0, smallest[ihwt_pkg::COUNT_BITS-1:1]});
      shin_r <= smallest[0];
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[ihwt_pkg::TOTAL_BITS-1:0] : trial[ihwt_pkg::TOTAL_BITS-1:0];
      quo_r  <= {quo_r[ihwt_pkg::WEIGHT_BITS-2:0], fits};
      shin_r <= 1'b0;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

/* rtl/core/inverse_histogram_weight_table.sv */
// ---------------------------------------------------------------------------
// inverse_histogram_weight_table
// Histogram bin table with running total, smallest count and weight reads.
// ---------------------------------------------------------------------------
// One command beat is taken at a time and gives one result beat. Clear,
// append, an unused command and a rejected read finish in the accept cycle,
// so their result is offered on the next cycle. A read of a stored bin first
// puts the stored count on the registered read port in ST_SETUP, where the
// divider is loaded, then spends ST_DIVIDE in the shared bit-serial divider
// until it signals done, and then hands the quotient over to the result
// beat. A read while the whole histogram is empty answers 1.0 from ST_SETUP.
// A new command is accepted only on the cycle after the previous result beat
// has been taken, so no command is taken while a read is still in progress.
// The count store needs no clearing: only entries below the fill level are
// ever read.
module inverse_histogram_weight_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ihwt_pkg::CMD_BITS-1:0]       in_cmd,
  input  logic [ihwt_pkg::IN_COUNT_BITS-1:0]  in_bin_count,
  input  logic [ihwt_pkg::IN_INDEX_BITS-1:0]  in_bin_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ihwt_pkg::WEIGHT_BITS-1:0]    out_weight,
  output logic [ihwt_pkg::STATUS_BITS-1:0]    out_status,
  output logic [ihwt_pkg::FILL_BITS-1:0]      out_filled_bins
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETUP  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_SPARE  = 4'b1000
  } seq_state_t;

  seq_state_t                        state_r, state_nxt;
  logic [ihwt_pkg::FILL_BITS-1:0]    fill_r, fill_nxt;
  logic [ihwt_pkg::TOTAL_BITS-1:0]   total_r, total_nxt;
  logic [ihwt_pkg::COUNT_BITS-1:0]   smallest_r, smallest_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [ihwt_pkg::WEIGHT_BITS-1:0]  weight_r, weight_nxt;
  logic [ihwt_pkg::STATUS_BITS-1:0]  status_r, status_nxt;
  logic [ihwt_pkg::FILL_BITS-1:0]    filled_r, filled_nxt;

  logic                              accept;
  logic                              produce;
  logic [ihwt_pkg::COUNT_BITS-1:0]   cnt;
  logic                              ram_we;
  logic                              ram_re;
  logic [ihwt_pkg::COUNT_BITS-1:0]   ram_rdata;
  logic                              div_start;
  logic [ihwt_pkg::TOTAL_BITS-1:0]   div_divisor;
  ihwt_pkg::div_status_t             div_stat;
  logic [ihwt_pkg::WEIGHT_BITS-1:0]  div_quo;

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign accept   = in_valid && in_ready;
  assign cnt      = in_bin_count[ihwt_pkg::COUNT_BITS-1:0];

  // Empty bins divide by the running total, stored bins by their count
  assign div_divisor = (ram_rdata != '0) ? ihwt_pkg::TOTAL_BITS'(ram_rdata) : total_r;

  // Count store
  ihwt_ram #(
    .WIDTH (ihwt_pkg::COUNT_BITS),
    .DEPTH (ihwt_pkg::MAX_BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[ihwt_pkg::IDX_BITS-1:0]),
    .wdata (cnt),
    .re    (ram_re),
    .raddr (in_bin_index[ihwt_pkg::IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Shared divider
  ihwt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .smallest (smallest_r),
    .divisor  (div_divisor),
    .status   (div_stat),
    .quotient (div_quo)
  );

  // Sequencer and table bookkeeping
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    smallest_nxt  = smallest_r;
    out_valid_nxt = out_valid_r;
    weight_nxt    = weight_r;
    status_nxt    = status_r;
    filled_nxt    = filled_r;
    produce       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    div_start     = 1'b0;

    // Drop the result beat once it is taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          weight_nxt = '0;
          status_nxt = ihwt_pkg::ST_OK;
          case (in_cmd)
            ihwt_pkg::CMD_CLEAR: begin
              fill_nxt     = '0;
              total_nxt    = '0;
              smallest_nxt = '1;
              produce      = 1'b1;
            end
            ihwt_pkg::CMD_APPEND: begin
              if (fill_r == ihwt_pkg::FILL_BITS'(ihwt_pkg::MAX_BINS)) begin
                status_nxt = ihwt_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                fill_nxt  = fill_r + 1'b1;
                total_nxt = total_r + ihwt_pkg::TOTAL_BITS'(cnt);
                if ((cnt != '0) && (cnt < smallest_r)) begin
                  smallest_nxt = cnt;
                end
              end
              produce = 1'b1;
            end
            ihwt_pkg::CMD_READ: begin
              if (ihwt_pkg::FILL_BITS'(in_bin_index) >= fill_r) begin
                status_nxt = ihwt_pkg::ST_RANGE;
                produce    = 1'b1;
              end else begin
                ram_re    = 1'b1;
                state_nxt = ST_SETUP;
              end
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      ST_SETUP: begin
        // Stored count is now on the read port
        if (total_r == '0) begin
          weight_nxt = ihwt_pkg::WEIGHT_ONE;
          status_nxt = ihwt_pkg::ST_OK;
          produce    = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          weight_nxt = div_quo;
          status_nxt = ihwt_pkg::ST_OK;
          produce    = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load the result beat
    if (produce) begin
      out_valid_nxt = 1'b1;
      filled_nxt    = fill_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      smallest_r  <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      smallest_r  <= smallest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    weight_r <= weight_nxt;
    status_r <= status_nxt;
    filled_r <= filled_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_weight      = weight_r;
  assign out_status      = status_r;
  assign out_filled_bins = filled_r;

endmodule

/* rtl/core/ihwt_checker.sv */
// ---------------------------------------------------------------------------
// ihwt_checker
// Port-level checks of the weight table, bound to the top level.
// ---------------------------------------------------------------------------
`include "inverse_histogram_weight_table_macros.svh"

module ihwt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [ihwt_pkg::CMD_BITS-1:0]       in_cmd,
  input logic [ihwt_pkg::IN_COUNT_BITS-1:0]  in_bin_count,
  input logic [ihwt_pkg::IN_INDEX_BITS-1:0]  in_bin_index,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [ihwt_pkg::WEIGHT_BITS-1:0]    out_weight,
  input logic [ihwt_pkg::STATUS_BITS-1:0]    out_status,
  input logic [ihwt_pkg::FILL_BITS-1:0]      out_filled_bins
);

  // A stalled result beat holds its payload
  `IHWT_ASSERT(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_weight) &&
    $stable(out_status) && $stable(out_filled_bins))

  // No command is taken while a result is still pending
  `IHWT_NEVER(a_one_in_flight, clk, rst_n, in_ready && out_valid)

  // A clear answers on the next cycle with an empty table
  `IHWT_ASSERT(a_clear_result, clk, rst_n,
    in_valid && in_ready && (in_cmd == ihwt_pkg::CMD_CLEAR) |=>
    out_valid && (out_filled_bins == '0) && (out_status == ihwt_pkg::ST_OK))

  // Failed commands carry no weight, and no weight exceeds one
  `IHWT_NEVER(a_weight_range, clk, rst_n,
    out_valid && ((out_weight > ihwt_pkg::WEIGHT_ONE) ||
    ((out_status != ihwt_pkg::ST_OK) && (out_weight != '0))))

endmodule

bind inverse_histogram_weight_table ihwt_checker u_ihwt_checker (.*);
